/* hw/rtl/mqttpp_pkg.sv */
// Shared types, widths and codes for the MQTT PUBLISH packet parser.
package mqttpp_pkg;

    // Field widths
    localparam int DATA_W = 8;
    localparam int LEN_W  = 28;
    localparam int TLEN_W = 16;
    localparam int MID_W  = 16;
    localparam int PCNT_W = 32;
    localparam int CAP_W  = 17;
    localparam int USER_W = 3;

    // Result tdata: 107 field bits padded to whole bytes
    localparam int M_TDATA_W = 112;
    localparam int M_PAD_W   = 5;

    // Defaults
    localparam int MAX_LEN_BYTES_DEF = 4;
    localparam logic [CAP_W-1:0] CAP_RESET = 17'd256;

    // Control packet type of a PUBLISH header
    localparam logic [3:0] PUBLISH_TYPE = 4'h3;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_TLEN_HI = 3'd2,
        PH_TLEN_LO = 3'd3,
        PH_TOPIC   = 3'd4,
        PH_MID_HI  = 3'd5,
        PH_MID_LO  = 3'd6,
        PH_PAYLOAD = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        CLS_HEADER    = 3'd0,
        CLS_LENGTH    = 3'd1,
        CLS_TOPIC_LEN = 3'd2,
        CLS_TOPIC     = 3'd3,
        CLS_MSG_ID    = 3'd4,
        CLS_PAYLOAD   = 3'd5,
        CLS_DISCARD   = 3'd6
    } byte_class_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_WRONG_TYPE = 3'd1,
        ST_LEN_LONG   = 3'd2,
        ST_TOPIC_LONG = 3'd3,
        ST_TRUNCATED  = 3'd4
    } status_t;

    // One input byte with its end-of-buffer flag
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
    } in_item_t;

    // One result item
    typedef struct packed {
        byte_class_t       byte_class;
        logic [DATA_W-1:0] data_out;
        logic              dup_flag;
        logic [1:0]        qos_level;
        logic              retain_flag;
        logic [LEN_W-1:0]  remaining_length;
        logic [TLEN_W-1:0] topic_length;
        logic [MID_W-1:0]  message_id;
        logic [PCNT_W-1:0] payload_count;
        status_t           status;
        logic              packet_done;
    } result_t;

endpackage

/* hw/rtl/mqtt_publish_parser.sv */
// Top level of the MQTT PUBLISH packet parser: ports, capacity register, stage wiring.
//
//   Channel  Direction  Handshake                    Contents
//   cfg      in         cfg_valid / cfg_ready        topic capacity (17 bits)
//   s_axis   in         s_axis_tvalid / tready       packet byte, tlast = last byte of buffer
//   m_axis   out        m_axis_tvalid / tready       decoded fields, tuser = byte class
//
// One byte per cycle sustained while m_axis_tready is high; a result passes the input
// register, then the result register, before it is valid on m_axis.
// The state update in the parse core, done in one step per byte, sets this rate.
// Reset (synchronous, aresetn low) returns the packet state to header and the
// topic capacity to 256. A stalled m_axis holds the result register and backs
// up to s_axis_tready through the input register; no byte is lost or repeated.
module mqtt_publish_parser #(
    parameter int MAX_LENGTH_BYTES = mqttpp_pkg::MAX_LEN_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write: topic_capacity
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mqttpp_pkg::CAP_W-1:0]        cfg_data,
    // Input bytes
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: [7:0] data_byte
    input  logic [mqttpp_pkg::DATA_W-1:0]       s_axis_tdata,
    input  logic                                s_axis_tlast,
    // Results
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: [7:0] data_out, [8] dup_flag, [10:9] qos_level, [11] retain_flag,
    //        [39:12] remaining_length, [55:40] topic_length, [71:56] message_id,
    //        [103:72] payload_count, [106:104] status, [111:107] zero
    output logic [mqttpp_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // tuser: [2:0] byte_class
    output logic [mqttpp_pkg::USER_W-1:0]       m_axis_tuser,
    output logic                                m_axis_tlast
);
    import mqttpp_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_next;

    in_item_t s_item;
    in_item_t in_item;
    logic     in_valid;
    logic     out_ready;
    logic     step;
    result_t  core_res;
    result_t  m_result;

    // Hold the topic capacity; writes are always taken
    assign cfg_ready = 1'b1;

    always_comb begin
        cap_next = cap_reg;
        if (cfg_valid && cfg_ready) begin
            cap_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else begin
            cap_reg <= cap_next;
        end
    end

    assign s_item.data = s_axis_tdata;
    assign s_item.last = s_axis_tlast;

    // A byte moves through the core when the result register has room
    assign step = in_valid && out_ready;

    mqttpp_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_item    (s_item),
        .out_ready (out_ready),
        .in_valid  (in_valid),
        .in_item   (in_item)
    );

    mqttpp_parse_core #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_parse_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .item           (in_item),
        .topic_capacity (cap_reg),
        .res            (core_res)
    );

    mqttpp_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .res_in    (core_res),
        .out_ready (out_ready),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_result  (m_result)
    );

    // Pack the result fields, highest field first
    assign m_axis_tdata = {
        {M_PAD_W{1'b0}},
        m_result.status,
        m_result.payload_count,
        m_result.message_id,
        m_result.topic_length,
        m_result.remaining_length,
        m_result.retain_flag,
        m_result.qos_level,
        m_result.dup_flag,
        m_result.data_out
    };
    assign m_axis_tuser = m_result.byte_class;
    assign m_axis_tlast = m_result.packet_done;

endmodule

/* hw/rtl/mqttpp_in_stage.sv */
// Input register stage of the parser: holds one accepted byte until the core takes it.
module mqttpp_in_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mqttpp_pkg::in_item_t s_item,
    input  logic                 out_ready,
    output logic                 in_valid,
    output mqttpp_pkg::in_item_t in_item
);
    import mqttpp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Accept while empty or while the held byte moves on this cycle
    assign s_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load the byte on each input transfer
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign in_valid = valid_reg;
    assign in_item  = item_reg;

endmodule

/* hw/rtl/mqttpp_parse_core.sv */
// Packet state machine and field decode: one byte taken in per step.
module mqttpp_parse_core #(
    parameter int MAX_LENGTH_BYTES = mqttpp_pkg::MAX_LEN_BYTES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               step,
    input  mqttpp_pkg::in_item_t               item,
    input  logic [mqttpp_pkg::CAP_W-1:0]       topic_capacity,
    output mqttpp_pkg::result_t                res
);
    import mqttpp_pkg::*;

    localparam int CNT_W = $clog2(MAX_LENGTH_BYTES + 1);

    // Packet state
    phase_t            phase_reg,    phase_next,    phase_upd;
    logic [CNT_W-1:0]  len_cnt_reg,  len_cnt_next,  len_cnt_upd;
    logic [LEN_W-1:0]  len_val_reg,  len_val_next,  len_val_upd;
    logic [3:0]        flags_reg,    flags_next,    flags_upd;
    logic [TLEN_W-1:0] topic_len_reg, topic_len_next, topic_len_upd;
    logic [TLEN_W-1:0] topic_left_reg, topic_left_next, topic_left_upd;
    logic [MID_W-1:0]  msg_id_reg,   msg_id_next,   msg_id_upd;
    logic [PCNT_W-1:0] pcnt_reg,     pcnt_next,     pcnt_upd;
    status_t           err_reg,      err_next,      err_upd;

    logic [LEN_W-1:0]  len_term;
    logic [TLEN_W-1:0] tlen_full;
    logic [CAP_W-1:0]  tlen_plus1;
    logic [TLEN_W-1:0] left_dec;
    phase_t            phase_after_topic;
    byte_class_t       byte_class;

    // Place the 7-bit group of this length byte at its base-128 position
    always_comb begin
        len_term = '0;
        for (int i = 0; i < MAX_LENGTH_BYTES; i++) begin
            if (len_cnt_reg == CNT_W'(i)) begin
                len_term = LEN_W'(item.data[6:0]) << (7 * i);
            end
        end
    end

    assign tlen_full  = topic_len_reg | {8'h00, item.data};
    assign tlen_plus1 = {1'b0, tlen_full} + CAP_W'(1);
    assign left_dec   = topic_left_reg - TLEN_W'(1);
    assign phase_after_topic = (flags_reg[2:1] != 2'b00) ? PH_MID_HI : PH_PAYLOAD;

    // Next state: update from this byte, then clear at the end of the buffer
    always_comb begin
        phase_upd      = phase_reg;
        len_cnt_upd    = len_cnt_reg;
        len_val_upd    = len_val_reg;
        flags_upd      = flags_reg;
        topic_len_upd  = topic_len_reg;
        topic_left_upd = topic_left_reg;
        msg_id_upd     = msg_id_reg;
        pcnt_upd       = pcnt_reg;
        err_upd        = err_reg;

        if (err_reg == ST_OK) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (item.data[7:4] != PUBLISH_TYPE) begin
                        err_upd = ST_WRONG_TYPE;
                    end else begin
                        flags_upd = item.data[3:0];
                    end
                    phase_upd = PH_LENGTH;
                end
                PH_LENGTH: begin
                    len_val_upd = len_val_reg + len_term;
                    len_cnt_upd = len_cnt_reg + CNT_W'(1);
                    if (!item.data[7]) begin
                        phase_upd = PH_TLEN_HI;
                    end else if (len_cnt_upd >= CNT_W'(MAX_LENGTH_BYTES)) begin
                        err_upd = ST_LEN_LONG;
                    end
                end
                PH_TLEN_HI: begin
                    topic_len_upd = {item.data, 8'h00};
                    phase_upd     = PH_TLEN_LO;
                end
                PH_TLEN_LO: begin
                    topic_len_upd = tlen_full;
                    if (tlen_plus1 > topic_capacity) begin
                        err_upd = ST_TOPIC_LONG;
                    end else begin
                        topic_left_upd = tlen_full;
                        phase_upd = (tlen_full != '0) ? PH_TOPIC : phase_after_topic;
                    end
                end
                PH_TOPIC: begin
                    topic_left_upd = left_dec;
                    if (left_dec == '0) begin
                        phase_upd = phase_after_topic;
                    end
                end
                PH_MID_HI: begin
                    msg_id_upd = {item.data, 8'h00};
                    phase_upd  = PH_MID_LO;
                end
                PH_MID_LO: begin
                    msg_id_upd = msg_id_reg | {8'h00, item.data};
                    phase_upd  = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    if (pcnt_reg != '1) begin
                        pcnt_upd = pcnt_reg + PCNT_W'(1);
                    end
                end
            endcase

            // Buffer ends before the payload is reached
            if (item.last && err_upd == ST_OK && phase_upd != PH_PAYLOAD) begin
                err_upd = ST_TRUNCATED;
            end
        end

        if (item.last) begin
            phase_next      = PH_HEADER;
            len_cnt_next    = '0;
            len_val_next    = '0;
            flags_next      = '0;
            topic_len_next  = '0;
            topic_left_next = '0;
            msg_id_next     = '0;
            pcnt_next       = '0;
            err_next        = ST_OK;
        end else begin
            phase_next      = phase_upd;
            len_cnt_next    = len_cnt_upd;
            len_val_next    = len_val_upd;
            flags_next      = flags_upd;
            topic_len_next  = topic_len_upd;
            topic_left_next = topic_left_upd;
            msg_id_next     = msg_id_upd;
            pcnt_next       = pcnt_upd;
            err_next        = err_upd;
        end
    end

    // Class of this byte: by phase, or discard once an error is held
    always_comb begin
        byte_class = CLS_DISCARD;
        if (err_reg == ST_OK) begin
            unique case (phase_reg)
                PH_HEADER:  byte_class = CLS_HEADER;
                PH_LENGTH:  byte_class = CLS_LENGTH;
                PH_TLEN_HI: byte_class = CLS_TOPIC_LEN;
                PH_TLEN_LO: byte_class = CLS_TOPIC_LEN;
                PH_TOPIC:   byte_class = CLS_TOPIC;
                PH_MID_HI:  byte_class = CLS_MSG_ID;
                PH_MID_LO:  byte_class = CLS_MSG_ID;
                PH_PAYLOAD: byte_class = CLS_PAYLOAD;
            endcase
        end
    end

    // Result shows the state after this byte, before the end-of-buffer clear
    always_comb begin
        res.byte_class       = byte_class;
        res.data_out         = item.data;
        res.dup_flag         = flags_upd[3];
        res.qos_level        = flags_upd[2:1];
        res.retain_flag      = flags_upd[0];
        res.remaining_length = len_val_upd;
        res.topic_length     = topic_len_upd;
        res.message_id       = msg_id_upd;
        res.payload_count    = pcnt_upd;
        res.status           = err_upd;
        res.packet_done      = item.last;
    end

    // Advance packet state on each step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            len_cnt_reg    <= '0;
            len_val_reg    <= '0;
            flags_reg      <= '0;
            topic_len_reg  <= '0;
            topic_left_reg <= '0;
            msg_id_reg     <= '0;
            pcnt_reg       <= '0;
            err_reg        <= ST_OK;
        end else if (step) begin
            phase_reg      <= phase_next;
            len_cnt_reg    <= len_cnt_next;
            len_val_reg    <= len_val_next;
            flags_reg      <= flags_next;
            topic_len_reg  <= topic_len_next;
            topic_left_reg <= topic_left_next;
            msg_id_reg     <= msg_id_next;
            pcnt_reg       <= pcnt_next;
            err_reg        <= err_next;
        end
    end

    // An error holds the packet state until the buffer ends
    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !item.last && err_reg != ST_OK) |=>
            ($stable(err_reg) && $stable(phase_reg) && $stable(pcnt_reg)))
        else $error("packet state changed after an error");

    // The end of a buffer leaves a clean header state
    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && item.last) |=>
            (phase_reg == PH_HEADER && err_reg == ST_OK && len_cnt_reg == '0))
        else $error("state not cleared after last byte");

    // Length byte count stays within the allowed field size
    a_len_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        len_cnt_reg <= CNT_W'(MAX_LENGTH_BYTES))
        else $error("length byte count out of range");

    // A discarded byte only occurs with an error already reported
    a_discard_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && byte_class == CLS_DISCARD) |-> (res.status != ST_OK))
        else $error("discarded byte without error status");

endmodule

/* hw/rtl/mqttpp_out_stage.sv */
// Result register stage of the parser: holds one result until the sink takes it.
module mqttpp_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  mqttpp_pkg::result_t res_in,
    output logic                out_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output mqttpp_pkg::result_t m_result
);
    import mqttpp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Room when empty or when the held result is taken this cycle
    assign out_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (out_ready) begin
            valid_next = step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture the result of each step
    always_ff @(posedge aclk) begin
        if (step) begin
            result_reg <= res_in;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule
